FILE: rtl/core/c_punctuator_tokenizer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the punctuator tokenizer
// Shared concurrent assertion forms used by the tokenizer modules.
// ----------------------------------------------------------------------------
`ifndef C_PUNCTUATOR_TOKENIZER_ASSERT_SVH
`define C_PUNCTUATOR_TOKENIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");

`endif

FILE: rtl/core/cpt_pkg.sv
// ----------------------------------------------------------------------------
// Punctuator tokenizer package
// Character codes, token kinds, prefix states and the classification tables.
// ----------------------------------------------------------------------------
package cpt_pkg;

    localparam int KIND_BITS = 6;
    localparam int MAX_TOK   = 3;
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = 2;
    localparam int QCNT_BITS = 3;

    // Source characters.
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_PIPE    = 8'h7C;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_EXCL    = 8'h21;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_CARET   = 8'h5E;

    // Token kinds.
    localparam logic [KIND_BITS-1:0] K_LBRACK   = 6'd0;
    localparam logic [KIND_BITS-1:0] K_RBRACK   = 6'd1;
    localparam logic [KIND_BITS-1:0] K_LPAREN   = 6'd2;
    localparam logic [KIND_BITS-1:0] K_RPAREN   = 6'd3;
    localparam logic [KIND_BITS-1:0] K_LBRACE   = 6'd4;
    localparam logic [KIND_BITS-1:0] K_RBRACE   = 6'd5;
    localparam logic [KIND_BITS-1:0] K_TILDE    = 6'd6;
    localparam logic [KIND_BITS-1:0] K_QUEST    = 6'd7;
    localparam logic [KIND_BITS-1:0] K_COLON    = 6'd8;
    localparam logic [KIND_BITS-1:0] K_SEMI     = 6'd9;
    localparam logic [KIND_BITS-1:0] K_COMMA    = 6'd10;
    localparam logic [KIND_BITS-1:0] K_PERIOD   = 6'd11;
    localparam logic [KIND_BITS-1:0] K_ELLIPSIS = 6'd12;
    localparam logic [KIND_BITS-1:0] K_AMP      = 6'd13;
    localparam logic [KIND_BITS-1:0] K_ANDAND   = 6'd14;
    localparam logic [KIND_BITS-1:0] K_ANDEQ    = 6'd15;
    localparam logic [KIND_BITS-1:0] K_STAR     = 6'd16;
    localparam logic [KIND_BITS-1:0] K_MULEQ    = 6'd17;
    localparam logic [KIND_BITS-1:0] K_PLUS     = 6'd18;
    localparam logic [KIND_BITS-1:0] K_INC      = 6'd19;
    localparam logic [KIND_BITS-1:0] K_ADDEQ    = 6'd20;
    localparam logic [KIND_BITS-1:0] K_MINUS    = 6'd21;
    localparam logic [KIND_BITS-1:0] K_ARROW    = 6'd22;
    localparam logic [KIND_BITS-1:0] K_DEC      = 6'd23;
    localparam logic [KIND_BITS-1:0] K_SUBEQ    = 6'd24;
    localparam logic [KIND_BITS-1:0] K_EXCL     = 6'd25;
    localparam logic [KIND_BITS-1:0] K_NE       = 6'd26;
    localparam logic [KIND_BITS-1:0] K_SLASH    = 6'd27;
    localparam logic [KIND_BITS-1:0] K_DIVEQ    = 6'd28;
    localparam logic [KIND_BITS-1:0] K_PERCENT  = 6'd29;
    localparam logic [KIND_BITS-1:0] K_MODEQ    = 6'd30;
    localparam logic [KIND_BITS-1:0] K_LT       = 6'd31;
    localparam logic [KIND_BITS-1:0] K_SHL      = 6'd32;
    localparam logic [KIND_BITS-1:0] K_SHLEQ    = 6'd33;
    localparam logic [KIND_BITS-1:0] K_LE       = 6'd34;
    localparam logic [KIND_BITS-1:0] K_GT       = 6'd35;
    localparam logic [KIND_BITS-1:0] K_SHR      = 6'd36;
    localparam logic [KIND_BITS-1:0] K_SHREQ    = 6'd37;
    localparam logic [KIND_BITS-1:0] K_GE       = 6'd38;
    localparam logic [KIND_BITS-1:0] K_CARET    = 6'd39;
    localparam logic [KIND_BITS-1:0] K_XOREQ    = 6'd40;
    localparam logic [KIND_BITS-1:0] K_PIPE     = 6'd41;
    localparam logic [KIND_BITS-1:0] K_OROR     = 6'd42;
    localparam logic [KIND_BITS-1:0] K_OREQ     = 6'd43;
    localparam logic [KIND_BITS-1:0] K_ASSIGN   = 6'd44;
    localparam logic [KIND_BITS-1:0] K_EQEQ     = 6'd45;
    localparam logic [KIND_BITS-1:0] K_HASH     = 6'd46;
    localparam logic [KIND_BITS-1:0] K_HASHHASH = 6'd47;
    localparam logic [KIND_BITS-1:0] K_BSLASH   = 6'd48;

    // Pending prefix, one-hot.
    typedef enum logic [17:0] {
        P_IDLE    = 18'h00001,
        P_DOT     = 18'h00002,
        P_DOTDOT  = 18'h00004,
        P_LT      = 18'h00008,
        P_LTLT    = 18'h00010,
        P_GT      = 18'h00020,
        P_GTGT    = 18'h00040,
        P_MINUS   = 18'h00080,
        P_AMP     = 18'h00100,
        P_PIPE    = 18'h00200,
        P_PLUS    = 18'h00400,
        P_EQ      = 18'h00800,
        P_HASH    = 18'h01000,
        P_STAR    = 18'h02000,
        P_EXCL    = 18'h04000,
        P_SLASH   = 18'h08000,
        P_PERCENT = 18'h10000,
        P_CARET   = 18'h20000
    } t_pfx;

    // Token kinds of one queue word; cnt is the number of valid slots.
    typedef struct packed {
        logic [1:0]                        cnt;
        logic [MAX_TOK-1:0][KIND_BITS-1:0] kind;
    } t_kinds;

    // Outcome of offering a byte to the pending prefix.
    typedef struct packed {
        logic                 fin;
        logic [KIND_BITS-1:0] fin_kind;
        logic                 took;
        t_pfx                 next;
    } t_ext;

    // Classification of a byte seen with nothing pending.
    typedef struct packed {
        logic                 single;
        logic [KIND_BITS-1:0] kind;
        t_pfx                 pfx;
    } t_fresh;

    // Token emitted when a pending prefix is flushed unextended.
    function automatic logic [KIND_BITS-1:0] base_kind(input t_pfx s);
        logic [KIND_BITS-1:0] k;
        case (s)
            P_DOT, P_DOTDOT: k = K_PERIOD;
            P_LT:            k = K_LT;
            P_LTLT:          k = K_SHL;
            P_GT:            k = K_GT;
            P_GTGT:          k = K_SHR;
            P_MINUS:         k = K_MINUS;
            P_AMP:           k = K_AMP;
            P_PIPE:          k = K_PIPE;
            P_PLUS:          k = K_PLUS;
            P_EQ:            k = K_ASSIGN;
            P_HASH:          k = K_HASH;
            P_STAR:          k = K_STAR;
            P_EXCL:          k = K_EXCL;
            P_SLASH:         k = K_SLASH;
            P_PERCENT:       k = K_PERCENT;
            P_CARET:         k = K_CARET;
            default:         k = K_PERIOD;
        endcase
        return k;
    endfunction

    function automatic t_ext extend(input t_pfx s, input logic [7:0] ch);
        t_ext e;
        e.fin      = 1'b0;
        e.fin_kind = K_PERIOD;
        e.took     = 1'b0;
        e.next     = P_IDLE;
        case (s)
            P_DOT: begin
                if (ch == CH_DOT) begin
                    e.took = 1'b1;
                    e.next = P_DOTDOT;
                end
            end
            P_DOTDOT: begin
                if (ch == CH_DOT) begin
                    e.fin = 1'b1; e.fin_kind = K_ELLIPSIS;
                end
            end
            P_LT: begin
                if (ch == CH_LT) begin
                    e.took = 1'b1;
                    e.next = P_LTLT;
                end else if (ch == CH_EQ) begin
                    e.fin = 1'b1; e.fin_kind = K_LE;
                end
            end
            P_LTLT: begin
                if (ch == CH_EQ) begin
                    e.fin = 1'b1; e.fin_kind = K_SHLEQ;
                end
            end
            P_GT: begin
                if (ch == CH_GT) begin
                    e.took = 1'b1;
                    e.next = P_GTGT;
                end else if (ch == CH_EQ) begin
                    e.fin = 1'b1; e.fin_kind = K_GE;
                end
            end
            P_GTGT: begin
                if (ch == CH_EQ) begin
                    e.fin = 1'b1; e.fin_kind = K_SHREQ;
                end
            end
            P_MINUS: begin
                if (ch == CH_GT) begin
                    e.fin = 1'b1; e.fin_kind = K_ARROW;
                end else if (ch == CH_MINUS) begin
                    e.fin = 1'b1; e.fin_kind = K_DEC;
                end else if (ch == CH_EQ) begin
                    e.fin = 1'b1; e.fin_kind = K_SUBEQ;
                end
            end
            P_AMP: begin
                if (ch == CH_AMP) begin
                    e.fin = 1'b1; e.fin_kind = K_ANDAND;
                end else if (ch == CH_EQ) begin
                    e.fin = 1'b1; e.fin_kind = K_ANDEQ;
                end
            end
            P_PIPE: begin
                if (ch == CH_PIPE) begin
                    e.fin = 1'b1; e.fin_kind = K_OROR;
                end else if (ch == CH_EQ) begin
                    e.fin = 1'b1; e.fin_kind = K_OREQ;
                end
            end
            P_PLUS: begin
                if (ch == CH_PLUS) begin
                    e.fin = 1'b1; e.fin_kind = K_INC;
                end else if (ch == CH_EQ) begin
                    e.fin = 1'b1; e.fin_kind = K_ADDEQ;
                end
            end
            P_EQ: begin
                if (ch == CH_EQ) begin
                    e.fin = 1'b1; e.fin_kind = K_EQEQ;
                end
            end
            P_HASH: begin
                if (ch == CH_HASH) begin
                    e.fin = 1'b1; e.fin_kind = K_HASHHASH;
                end
            end
            P_STAR: begin
                if (ch == CH_EQ) begin
                    e.fin = 1'b1; e.fin_kind = K_MULEQ;
                end
            end
            P_EXCL: begin
                if (ch == CH_EQ) begin
                    e.fin = 1'b1; e.fin_kind = K_NE;
                end
            end
            P_SLASH: begin
                if (ch == CH_EQ) begin
                    e.fin = 1'b1; e.fin_kind = K_DIVEQ;
                end
            end
            P_PERCENT: begin
                if (ch == CH_EQ) begin
                    e.fin = 1'b1; e.fin_kind = K_MODEQ;
                end
            end
            P_CARET: begin
                if (ch == CH_EQ) begin
                    e.fin = 1'b1; e.fin_kind = K_XOREQ;
                end
            end
            default: begin
                e.fin = 1'b0;
            end
        endcase
        return e;
    endfunction

    function automatic t_fresh fresh(input logic [7:0] ch);
        t_fresh f;
        f.single = 1'b0;
        f.kind   = K_LBRACK;
        f.pfx    = P_IDLE;
        case (ch)
            CH_LBRACK:  begin f.single = 1'b1; f.kind = K_LBRACK; end
            CH_RBRACK:  begin f.single = 1'b1; f.kind = K_RBRACK; end
            CH_LPAREN:  begin f.single = 1'b1; f.kind = K_LPAREN; end
            CH_RPAREN:  begin f.single = 1'b1; f.kind = K_RPAREN; end
            CH_LBRACE:  begin f.single = 1'b1; f.kind = K_LBRACE; end
            CH_RBRACE:  begin f.single = 1'b1; f.kind = K_RBRACE; end
            CH_TILDE:   begin f.single = 1'b1; f.kind = K_TILDE; end
            CH_QUEST:   begin f.single = 1'b1; f.kind = K_QUEST; end
            CH_COLON:   begin f.single = 1'b1; f.kind = K_COLON; end
            CH_SEMI:    begin f.single = 1'b1; f.kind = K_SEMI; end
            CH_COMMA:   begin f.single = 1'b1; f.kind = K_COMMA; end
            CH_BSLASH:  begin f.single = 1'b1; f.kind = K_BSLASH; end
            CH_DOT:     f.pfx = P_DOT;
            CH_LT:      f.pfx = P_LT;
            CH_GT:      f.pfx = P_GT;
            CH_MINUS:   f.pfx = P_MINUS;
            CH_AMP:     f.pfx = P_AMP;
            CH_PIPE:    f.pfx = P_PIPE;
            CH_PLUS:    f.pfx = P_PLUS;
            CH_EQ:      f.pfx = P_EQ;
            CH_HASH:    f.pfx = P_HASH;
            CH_STAR:    f.pfx = P_STAR;
            CH_EXCL:    f.pfx = P_EXCL;
            CH_SLASH:   f.pfx = P_SLASH;
            CH_PERCENT: f.pfx = P_PERCENT;
            CH_CARET:   f.pfx = P_CARET;
            default:    f.pfx = P_IDLE;
        endcase
        return f;
    endfunction

endpackage

FILE: rtl/core/c_punctuator_tokenizer.sv
// ----------------------------------------------------------------------------
// C punctuator tokenizer
// Longest-match recognizer for C punctuators, one source byte per word.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake           Fields
//  -------   -----------------   -----------------------------------------
//  input     push / full         i_ch, i_line, i_column, i_end_of_input
//  result    pop / empty         o_kind, o_tok_line, o_tok_column, o_last
//
// A byte is taken every cycle that the token queue has room; the prefix
// state machine settles each byte in the cycle it is accepted.
// Each byte yields zero to three tokens, delivered one word per cycle while
// pop is asserted from the four-entry token queue, so sustained throughput is
// one byte per cycle as long as bytes average no more than one token each.
// Tokens are registered in the token queue; the ports show its head entry.
// Reset (synchronous, active low) empties the queue and clears any pending
// prefix; full holds only while four token groups wait to be popped.
//
module c_punctuator_tokenizer #(
    parameter int LINE_BITS   = 24,
    parameter int COLUMN_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    i_ch,
    input  logic [LINE_BITS-1:0]          i_line,
    input  logic [COLUMN_BITS-1:0]        i_column,
    input  logic                          i_end_of_input,
    output logic                          empty,
    input  logic                          pop,
    output logic [cpt_pkg::KIND_BITS-1:0] o_kind,
    output logic [LINE_BITS-1:0]          o_tok_line,
    output logic [COLUMN_BITS-1:0]        o_tok_column,
    output logic                          o_last
);

    // The front end moves its prefix state on every accepted byte, even one
    // that produces no token (for example a byte that extends a prefix).
    logic                                         accept;
    logic                                         fe_wr;
    cpt_pkg::t_kinds                              fe_kinds;
    logic [cpt_pkg::MAX_TOK-1:0][LINE_BITS-1:0]   fe_line;
    logic [cpt_pkg::MAX_TOK-1:0][COLUMN_BITS-1:0] fe_col;

    // Head of the token queue as seen by the back end.
    cpt_pkg::t_kinds                              q_kinds;
    logic [cpt_pkg::MAX_TOK-1:0][LINE_BITS-1:0]   q_line;
    logic [cpt_pkg::MAX_TOK-1:0][COLUMN_BITS-1:0] q_col;
    logic                                         q_empty;
    logic                                         q_full;
    logic                                         be_deq;

    assign full   = q_full;
    assign empty  = q_empty;
    assign accept = push && !q_full;

    cpt_front #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_ch           (i_ch),
        .i_line         (i_line),
        .i_column       (i_column),
        .i_end_of_input (i_end_of_input),
        .o_wr           (fe_wr),
        .o_kinds        (fe_kinds),
        .o_line         (fe_line),
        .o_col          (fe_col)
    );

    // Each entry holds every token that one byte caused, so the front end
    // never needs more than one write per accepted byte.
    cpt_queue #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fe_wr),
        .i_kinds (fe_kinds),
        .i_line  (fe_line),
        .i_col   (fe_col),
        .i_rd    (be_deq),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_kinds (q_kinds),
        .o_line  (q_line),
        .o_col   (q_col)
    );

    // The back end walks through the tokens of the head entry and releases
    // the entry when its last token is popped.
    cpt_back #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_kinds (q_kinds),
        .i_line  (q_line),
        .i_col   (q_col),
        .i_pop   (pop),
        .o_deq   (be_deq),
        .o_kind  (o_kind),
        .o_line  (o_tok_line),
        .o_col   (o_tok_column),
        .o_last  (o_last)
    );

endmodule

FILE: rtl/core/cpt_front.sv
// ----------------------------------------------------------------------------
// Tokenizer front end
// Prefix state machine: turns each accepted byte into zero to three tokens.
// ----------------------------------------------------------------------------
`include "c_punctuator_tokenizer_assert.svh"

module cpt_front #(
    parameter int LINE_BITS   = 24,
    parameter int COLUMN_BITS = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_accept,
    input  logic [7:0]                                 i_ch,
    input  logic [LINE_BITS-1:0]                       i_line,
    input  logic [COLUMN_BITS-1:0]                     i_column,
    input  logic                                       i_end_of_input,
    output logic                                       o_wr,
    output cpt_pkg::t_kinds                            o_kinds,
    output logic [cpt_pkg::MAX_TOK-1:0][LINE_BITS-1:0]   o_line,
    output logic [cpt_pkg::MAX_TOK-1:0][COLUMN_BITS-1:0] o_col
);

    cpt_pkg::t_pfx            r_state, n_state;
    logic [LINE_BITS-1:0]     r_hl0, n_hl0, r_hl1, n_hl1;
    logic [COLUMN_BITS-1:0]   r_hc0, n_hc0, r_hc1, n_hc1;
    cpt_pkg::t_ext            ext;
    cpt_pkg::t_fresh          fr;

    assign ext = cpt_pkg::extend(r_state, i_ch);
    assign fr  = cpt_pkg::fresh(i_ch);

    always_comb begin
        logic [1:0] cnt;
        cnt     = 2'd0;
        n_state = r_state;
        n_hl0   = r_hl0;
        n_hc0   = r_hc0;
        n_hl1   = r_hl1;
        n_hc1   = r_hc1;
        o_kinds = '0;
        o_line  = '0;
        o_col   = '0;
        if (!i_end_of_input && ext.fin) begin
            o_kinds.kind[0] = ext.fin_kind;
            o_line[0]       = r_hl0;
            o_col[0]        = r_hc0;
            cnt             = 2'd1;
            n_state         = cpt_pkg::P_IDLE;
        end else if (!i_end_of_input && ext.took) begin
            n_state = ext.next;
            if (r_state == cpt_pkg::P_DOT) begin
                n_hl1 = i_line;
                n_hc1 = i_column;
            end
        end else begin
            // Flush whatever is pending, then, unless input has ended, look at the byte afresh.
            if (r_state != cpt_pkg::P_IDLE) begin
                o_kinds.kind[cnt] = cpt_pkg::base_kind(r_state);
                o_line[cnt]       = r_hl0;
                o_col[cnt]        = r_hc0;
                cnt               = cnt + 2'd1;
            end
            if (r_state == cpt_pkg::P_DOTDOT) begin
                o_kinds.kind[cnt] = cpt_pkg::K_PERIOD;
                o_line[cnt]       = r_hl1;
                o_col[cnt]        = r_hc1;
                cnt               = cnt + 2'd1;
            end
            n_state = cpt_pkg::P_IDLE;
            if (!i_end_of_input) begin
                if (fr.single) begin
                    o_kinds.kind[cnt] = fr.kind;
                    o_line[cnt]       = i_line;
                    o_col[cnt]        = i_column;
                    cnt               = cnt + 2'd1;
                end else if (fr.pfx != cpt_pkg::P_IDLE) begin
                    n_state = fr.pfx;
                    n_hl0   = i_line;
                    n_hc0   = i_column;
                end
            end
        end
        o_kinds.cnt = cnt;
    end

    assign o_wr = i_accept && (o_kinds.cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpt_pkg::P_IDLE;
            r_hl0   <= '0;
            r_hc0   <= '0;
            r_hl1   <= '0;
            r_hc1   <= '0;
        end else if (i_accept) begin
            r_state <= n_state;
            r_hl0   <= n_hl0;
            r_hc0   <= n_hc0;
            r_hl1   <= n_hl1;
            r_hc1   <= n_hc1;
        end
    end

    `CPT_ASSERT_NEXT(a_eoi_idles, i_clk, i_rst_n, i_accept && i_end_of_input,
        r_state == cpt_pkg::P_IDLE)
    `CPT_ASSERT_NOW(a_dotdot_flush_two, i_clk, i_rst_n,
        (r_state == cpt_pkg::P_DOTDOT) && i_end_of_input, o_kinds.cnt == 2'd2)

endmodule

FILE: rtl/core/cpt_queue.sv
// ----------------------------------------------------------------------------
// Tokenizer token queue
// Small queue of token groups between the front end and the back end.
// ----------------------------------------------------------------------------
`include "c_punctuator_tokenizer_assert.svh"

module cpt_queue #(
    parameter int LINE_BITS   = 24,
    parameter int COLUMN_BITS = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_wr,
    input  cpt_pkg::t_kinds                            i_kinds,
    input  logic [cpt_pkg::MAX_TOK-1:0][LINE_BITS-1:0]   i_line,
    input  logic [cpt_pkg::MAX_TOK-1:0][COLUMN_BITS-1:0] i_col,
    input  logic                                       i_rd,
    output logic                                       o_full,
    output logic                                       o_empty,
    output cpt_pkg::t_kinds                            o_kinds,
    output logic [cpt_pkg::MAX_TOK-1:0][LINE_BITS-1:0]   o_line,
    output logic [cpt_pkg::MAX_TOK-1:0][COLUMN_BITS-1:0] o_col
);

    cpt_pkg::t_kinds                               r_kinds [cpt_pkg::QDEPTH];
    logic [cpt_pkg::MAX_TOK-1:0][LINE_BITS-1:0]   r_line  [cpt_pkg::QDEPTH];
    logic [cpt_pkg::MAX_TOK-1:0][COLUMN_BITS-1:0] r_col   [cpt_pkg::QDEPTH];
    logic [cpt_pkg::QPTR_BITS-1:0]                r_wptr, r_rptr;
    logic [cpt_pkg::QCNT_BITS-1:0]                r_count;
    logic                                         wr_en, rd_en;

    assign o_full  = (r_count == cpt_pkg::QCNT_BITS'(cpt_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;

    assign o_kinds = r_kinds[r_rptr];
    assign o_line  = r_line[r_rptr];
    assign o_col   = r_col[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_kinds[r_wptr] <= i_kinds;
            r_line[r_wptr]  <= i_line;
            r_col[r_wptr]   <= i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= r_wptr + cpt_pkg::QPTR_BITS'(1);
            end
            if (rd_en) begin
                r_rptr <= r_rptr + cpt_pkg::QPTR_BITS'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + cpt_pkg::QCNT_BITS'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - cpt_pkg::QCNT_BITS'(1);
            end
        end
    end

    `CPT_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= cpt_pkg::QCNT_BITS'(cpt_pkg::QDEPTH))
    `CPT_ASSERT_NOW(a_head_nonempty, i_clk, i_rst_n, !o_empty, o_kinds.cnt != 2'd0)

endmodule

FILE: rtl/core/cpt_back.sv
// ----------------------------------------------------------------------------
// Tokenizer back end
// Delivers the tokens of the head queue entry one word at a time.
// ----------------------------------------------------------------------------
`include "c_punctuator_tokenizer_assert.svh"

module cpt_back #(
    parameter int LINE_BITS   = 24,
    parameter int COLUMN_BITS = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_empty,
    input  cpt_pkg::t_kinds                            i_kinds,
    input  logic [cpt_pkg::MAX_TOK-1:0][LINE_BITS-1:0]   i_line,
    input  logic [cpt_pkg::MAX_TOK-1:0][COLUMN_BITS-1:0] i_col,
    input  logic                                       i_pop,
    output logic                                       o_deq,
    output logic [cpt_pkg::KIND_BITS-1:0]              o_kind,
    output logic [LINE_BITS-1:0]                       o_line,
    output logic [COLUMN_BITS-1:0]                     o_col,
    output logic                                       o_last
);

    logic [1:0] r_idx;
    logic       take;

    assign o_kind = i_kinds.kind[r_idx];
    assign o_line = i_line[r_idx];
    assign o_col  = i_col[r_idx];
    assign o_last = (r_idx == (i_kinds.cnt - 2'd1));
    assign take   = i_pop && !i_empty;
    assign o_deq  = take && o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (take) begin
            r_idx <= o_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    `CPT_ASSERT_NOW(a_idx_in_group, i_clk, i_rst_n, !i_empty, r_idx < i_kinds.cnt)

endmodule
